// ===== rtl/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg: shared types, constants and microcode for the radix text core
// Holds the field widths, register codes, control word layout and the
// read-only program that drives the datapath.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int NUMBER_W       = 32;
  localparam int CHAR_W         = 8;
  localparam int RADIX_W        = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int SYM_SLOTS      = 16;
  localparam int SYM_IDX_W      = 4;
  localparam int DEF_MAX_RADIX  = 16;
  localparam int DEF_VALUE_BITS = 32;
  localparam int STEP_BITS      = 8;
  localparam int PC_W           = 3;

  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX     = 3'd0,
    REG_SYM_0_3   = 3'd1,
    REG_SYM_4_7   = 3'd2,
    REG_SYM_8_11  = 3'd3,
    REG_SYM_12_15 = 3'd4
  } cfg_reg_t;

  typedef logic [SYM_SLOTS-1:0][CHAR_W-1:0] sym_table_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MINUS,
    OP_DIV,
    OP_PUSH,
    OP_POP
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_ACCEPT,
    C_TABLE_BAD,
    C_POSITIVE,
    C_OUT_BUSY,
    C_DIV_MORE,
    C_MAG_NZ,
    C_POP_MORE
  } cond_t;

  typedef struct packed {
    logic             in_ready;
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic table_ok;
    logic negative;
    logic div_last;
    logic mag_nz;
    logic out_busy;
    logic sp_one;
    logic stack_empty;
  } status_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 3'd1;
  localparam logic [PC_W-1:0] PC_SIGN  = 3'd2;
  localparam logic [PC_W-1:0] PC_MINUS = 3'd3;
  localparam logic [PC_W-1:0] PC_DIV   = 3'd4;
  localparam logic [PC_W-1:0] PC_PUSH  = 3'd5;
  localparam logic [PC_W-1:0] PC_POP   = 3'd6;
  localparam logic [PC_W-1:0] PC_DONE  = 3'd7;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:  w = ctrl_t'{1'b1, OP_LOAD,  C_NO_ACCEPT, PC_IDLE};
      PC_CHECK: w = ctrl_t'{1'b0, OP_NONE,  C_TABLE_BAD, PC_IDLE};
      PC_SIGN:  w = ctrl_t'{1'b0, OP_NONE,  C_POSITIVE,  PC_DIV};
      PC_MINUS: w = ctrl_t'{1'b0, OP_MINUS, C_OUT_BUSY,  PC_MINUS};
      PC_DIV:   w = ctrl_t'{1'b0, OP_DIV,   C_DIV_MORE,  PC_DIV};
      PC_PUSH:  w = ctrl_t'{1'b0, OP_PUSH,  C_MAG_NZ,    PC_DIV};
      PC_POP:   w = ctrl_t'{1'b0, OP_POP,   C_POP_MORE,  PC_POP};
      PC_DONE:  w = ctrl_t'{1'b0, OP_NONE,  C_ALWAYS,    PC_IDLE};
      default:  w = ctrl_t'{1'b0, OP_NONE,  C_ALWAYS,    PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/itrd_if.sv =====
// ----------------------------------------------------------------------------
// itrd_if: valid/ready channels of the radix text core
// Input number channel, output character channel and configuration writes.
// ----------------------------------------------------------------------------
interface itrd_item_if import itrd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface itrd_char_if import itrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface itrd_cfg_if import itrd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/integer_to_radix_digits_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core: signed integer to radix text
// Takes a number in idle, checks the table (a bad table drops it), emits a minus
//   sign if negative, then divides by the radix in the 8-bit-per-cycle divider,
//   stacking one remainder digit per division until the magnitude is zero, and
//   pops the digits out. The next number is taken only after the last digit pops.
// Reset: synchronous; zeroes config, out valid, sp and dcnt; sequencer to idle.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core import itrd_pkg::*; #(
  parameter int MAX_RADIX  = DEF_MAX_RADIX,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  itrd_item_if.sink   items,
  itrd_char_if.source chars,
  itrd_cfg_if.sink    cfg
);

  logic [RADIX_W-1:0] radix;
  sym_table_t         symbols;
  logic               table_ok;
  ctrl_t              ctrl;
  status_t            status;

  itrd_cfg_regs #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .radix    (radix),
    .symbols  (symbols),
    .table_ok (table_ok)
  );

  itrd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  itrd_datapath #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .chars    (chars),
    .ctrl     (ctrl),
    .radix    (radix),
    .symbols  (symbols),
    .table_ok (table_ok),
    .status   (status)
  );

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> status.stack_empty)
    else $error("digit stack not empty while taking a new number");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_POP |-> !status.stack_empty)
    else $error("digit pop from empty stack");

  a_last_not_minus: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.last |-> chars.character != SYM_MINUS)
    else $error("minus sign flagged as final character");

endmodule

// ===== rtl/itrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// itrd_cfg_regs: configuration registers and symbol table check
// Stores radix and the sixteen digit symbols and keeps a registered flag
// telling whether the table in use is valid.
// ----------------------------------------------------------------------------
module itrd_cfg_regs import itrd_pkg::*; #(
  parameter int MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic               clk,
  input  logic               rst,
  itrd_cfg_if.sink           cfg,
  output logic [RADIX_W-1:0] radix,
  output sym_table_t         symbols,
  output logic               table_ok
);

  logic bad;
  logic table_ok_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
    for (int a = 0; a < SYM_SLOTS; a++) begin
      if (RADIX_W'(a) < radix) begin
        if (symbols[a] == SYM_PLUS || symbols[a] == SYM_MINUS) begin
          bad = 1'b1;
        end
        for (int b = a + 1; b < SYM_SLOTS; b++) begin
          if (RADIX_W'(b) < radix && symbols[a] == symbols[b]) begin
            bad = 1'b1;
          end
        end
      end
    end
    table_ok_next = !bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= '0;
      symbols  <= '0;
      table_ok <= 1'b0;
    end else begin
      table_ok <= table_ok_next;
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_RADIX:     radix          <= cfg.data[RADIX_W-1:0];
          REG_SYM_0_3:   symbols[3:0]   <= cfg.data;
          REG_SYM_4_7:   symbols[7:4]   <= cfg.data;
          REG_SYM_8_11:  symbols[11:8]  <= cfg.data;
          REG_SYM_12_15: symbols[15:12] <= cfg.data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/itrd_sequencer.sv =====
// ----------------------------------------------------------------------------
// itrd_sequencer: microprogram step counter
// Fetches one control word per step from the program table and branches
// on datapath status.
// ----------------------------------------------------------------------------
module itrd_sequencer import itrd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  assign ctrl = ucode(pc);

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:    jump = 1'b1;
      C_NO_ACCEPT: jump = !(status.in_valid && ctrl.in_ready);
      C_TABLE_BAD: jump = !status.table_ok;
      C_POSITIVE:  jump = !status.negative;
      C_OUT_BUSY:  jump = status.out_busy;
      C_DIV_MORE:  jump = !status.div_last;
      C_MAG_NZ:    jump = status.mag_nz;
      C_POP_MORE:  jump = status.out_busy || !status.sp_one;
      default:     jump = 1'b0;
    endcase
    pc_next = jump ? ctrl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/itrd_datapath.sv =====
// ----------------------------------------------------------------------------
// itrd_datapath: magnitude divider, digit stack and output register
// Divides the magnitude by the radix eight quotient bits per cycle, stacks
// the remainders and pops them out as symbols, most significant first.
// ----------------------------------------------------------------------------
module itrd_datapath import itrd_pkg::*; #(
  parameter int MAX_RADIX  = DEF_MAX_RADIX,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  itrd_item_if.sink          items,
  itrd_char_if.source        chars,
  input  ctrl_t              ctrl,
  input  logic [RADIX_W-1:0] radix,
  input  sym_table_t         symbols,
  input  logic               table_ok,
  output status_t            status
);

  localparam int DIV_STEPS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W       = DIV_STEPS * STEP_BITS;
  localparam int DCNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int DIGIT_W     = $clog2(MAX_RADIX);
  localparam int SP_W        = $clog2(VALUE_BITS + 1);
  localparam int STACK_IDX_W = $clog2(VALUE_BITS);
  localparam int CMP_W       = RADIX_W + 1;

  logic [DIV_W-1:0]      mag;
  logic                  negative;
  logic [DIGIT_W-1:0]    rem;
  logic [DCNT_W-1:0]     dcnt;
  logic [DIGIT_W-1:0]    stack [VALUE_BITS];
  logic [SP_W-1:0]       sp;
  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_last;

  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] v_abs;
  logic [DIV_W-1:0]      q;
  logic [DIGIT_W-1:0]    r;
  logic [DIGIT_W:0]      trial;
  logic [CMP_W-1:0]      diff;
  logic [SP_W-1:0]       sp_dec;
  logic [DIGIT_W-1:0]    top_digit;
  logic                  accept;
  logic                  out_free;
  logic                  out_set;

  assign v      = items.number[VALUE_BITS-1:0];
  assign v_abs  = v[VALUE_BITS-1] ? (~v) + VALUE_BITS'(1) : v;
  assign accept = items.valid && ctrl.in_ready;

  always_comb begin
    r     = rem;
    q     = mag;
    trial = '0;
    diff  = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, q[DIV_W-1]};
      q     = {q[DIV_W-2:0], 1'b0};
      diff  = CMP_W'(trial) - CMP_W'(radix);
      if (CMP_W'(trial) >= CMP_W'(radix)) begin
        r    = diff[DIGIT_W-1:0];
        q[0] = 1'b1;
      end else begin
        r = trial[DIGIT_W-1:0];
      end
    end
  end

  assign sp_dec    = sp - SP_W'(1);
  assign top_digit = stack[sp_dec[STACK_IDX_W-1:0]];
  assign out_free  = !out_valid || chars.ready;
  assign out_set   = ((ctrl.op == OP_MINUS) || (ctrl.op == OP_POP)) && out_free;

  assign items.ready     = ctrl.in_ready;
  assign chars.valid     = out_valid;
  assign chars.character = out_char;
  assign chars.last      = out_last;

  assign status.in_valid    = items.valid;
  assign status.table_ok    = table_ok;
  assign status.negative    = negative;
  assign status.div_last    = (dcnt == DCNT_W'(DIV_STEPS - 1));
  assign status.mag_nz      = |mag;
  assign status.out_busy    = !out_free;
  assign status.sp_one      = (sp == SP_W'(1));
  assign status.stack_empty = (sp == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sp        <= '0;
      dcnt      <= '0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && chars.ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_LOAD: begin
          if (accept) begin
            dcnt <= '0;
          end
        end
        OP_DIV: dcnt <= dcnt + DCNT_W'(1);
        OP_PUSH: begin
          sp   <= sp + SP_W'(1);
          dcnt <= '0;
        end
        OP_POP: begin
          if (out_free) begin
            sp <= sp_dec;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (accept) begin
          mag      <= DIV_W'(v_abs);
          negative <= v[VALUE_BITS-1];
          rem      <= '0;
        end
      end
      OP_DIV: begin
        mag <= q;
        rem <= r;
      end
      OP_PUSH: begin
        stack[sp[STACK_IDX_W-1:0]] <= rem;
        rem                        <= '0;
      end
      OP_MINUS: begin
        if (out_free) begin
          out_char <= SYM_MINUS;
          out_last <= 1'b0;
        end
      end
      OP_POP: begin
        if (out_free) begin
          out_char <= symbols[SYM_IDX_W'(top_digit)];
          out_last <= (sp == SP_W'(1));
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== bench/integer_to_radix_digits_core_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core_test: self-checking bench for the radix text core
// Loads digit tables through the register port, streams signed numbers in and
// checks every emitted character and last flag against an in-bench renderer.
// Covers bad tables, unused register indexes 5 and 7, extreme values and random
// numbers under several tables, with random stalls on both channels.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core_test;
  import itrd_pkg::*;

  localparam int MAX_DIGITS     = DEF_VALUE_BITS + 1;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_NUMBERS = 125;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst;

  itrd_item_if items_ch();
  itrd_char_if chars_ch();
  itrd_cfg_if  cfg_ch();

  integer_to_radix_digits_core DUT (
    .clk   (clk),
    .rst   (rst),
    .items (items_ch),
    .chars (chars_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [RADIX_W-1:0]       radix_setting;
  sym_table_t               symbol_bytes;
  logic signed [NUMBER_W-1:0] number_queue[$];
  text_char_t               expected_text[$];
  int                       mismatch_count = 0;
  int                       stall_cycles = 0;
  int                       sender_idle_pct = 0;
  int                       receiver_idle_pct = 0;
  bit                       number_taken = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic bit table_valid();
    if (radix_setting < 2 || radix_setting > DEF_MAX_RADIX) return 1'b0;
    for (int a = 0; a < radix_setting; a++) begin
      if (symbol_bytes[a] == SYM_PLUS || symbol_bytes[a] == SYM_MINUS) return 1'b0;
      for (int b = a + 1; b < radix_setting; b++)
        if (symbol_bytes[a] == symbol_bytes[b]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_RADIX:     radix_setting = data[RADIX_W-1:0];
      REG_SYM_0_3:   symbol_bytes[3:0] = data;
      REG_SYM_4_7:   symbol_bytes[7:4] = data;
      REG_SYM_8_11:  symbol_bytes[11:8] = data;
      REG_SYM_12_15: symbol_bytes[15:12] = data;
      default:       ;
    endcase
  endfunction

  function automatic void spell_number(input logic signed [NUMBER_W-1:0] n);
    logic [NUMBER_W-1:0] magnitude;
    logic [SYM_IDX_W-1:0] digits[MAX_DIGITS];
    int count;
    if (!table_valid()) return;
    magnitude = n;
    if (n[NUMBER_W-1]) begin
      expected_text.push_back('{SYM_MINUS, 1'b0});
      magnitude = -n;
    end
    count = 0;
    do begin
      digits[count] = SYM_IDX_W'(magnitude % radix_setting);
      magnitude = magnitude / radix_setting;
      count++;
    end while (magnitude != 0 && count < MAX_DIGITS);
    for (int k = count - 1; k >= 0; k--)
      expected_text.push_back('{symbol_bytes[digits[k]], k == 0});
  endfunction

  // Number sender
  always @(negedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else if (items_ch.valid && !number_taken) begin
      // hold the offer until it transfers
    end else if (number_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      items_ch.valid  <= 1'b1;
      items_ch.number <= number_queue.pop_front();
    end else begin
      items_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    chars_ch.ready <= $urandom_range(0, 99) >= receiver_idle_pct;
  end

  // Transfer monitor and checker
  always @(posedge clk) begin
    text_char_t want;
    number_taken = items_ch.valid && items_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.index, cfg_ch.data);
      if (number_taken) spell_number(items_ch.number);
      if (chars_ch.valid && chars_ch.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected character %h last %b",
                                    chars_ch.character, chars_ch.last));
        end else begin
          want = expected_text.pop_front();
          if (chars_ch.character !== want.character || chars_ch.last !== want.last)
            report_mismatch($sformatf("character %h last %b, want %h last %b",
                                      chars_ch.character, chars_ch.last,
                                      want.character, want.last));
        end
      end
      if (number_taken || (cfg_ch.valid && cfg_ch.ready) || (chars_ch.valid && chars_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic release_config();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_table(input logic [CFG_DATA_W-1:0] radix_word,
                            input sym_table_t tbl);
    write_register(REG_RADIX, radix_word);
    write_register(REG_SYM_0_3, tbl[3:0]);
    write_register(REG_SYM_4_7, tbl[7:4]);
    write_register(REG_SYM_8_11, tbl[11:8]);
    write_register(REG_SYM_12_15, tbl[15:12]);
    release_config();
  endtask

  task automatic settle();
    while (number_queue.size() != 0 || items_ch.valid || expected_text.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sym_table_t random_alphabet();
    sym_table_t tbl;
    logic [CHAR_W-1:0] b;
    bit clash;
    for (int i = 0; i < SYM_SLOTS; i++) begin
      do begin
        b = CHAR_W'($urandom_range(0, 255));
        clash = (b == SYM_PLUS) || (b == SYM_MINUS);
        for (int j = 0; j < i; j++)
          if (tbl[j] == b) clash = 1'b1;
      end while (clash);
      tbl[i] = b;
    end
    return tbl;
  endfunction

  function automatic logic signed [NUMBER_W-1:0] random_number(input int r);
    int p;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 300);
      2: return -$urandom_range(1, 300);
      3: begin
        p = 1;
        repeat ($urandom_range(1, 5)) p = p * r;
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? p : -p;
      end
      4: case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  sym_table_t decimal_digits = {32'h4645_4443, 32'h4241_3938, 32'h3736_3534, 32'h3332_3130};
  sym_table_t hex_digits     = {32'h6665_6463, 32'h6261_3938, 32'h3736_3534, 32'h3332_3130};
  sym_table_t binary_bytes   = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0100};

  initial begin
    sym_table_t tbl;
    int random_sent;
    int round_len;
    int r;
    rst = 1'b1;
    items_ch.valid  = 1'b0;
    items_ch.number = '0;
    chars_ch.ready  = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_RADIX;
    cfg_ch.data     = '0;
    radix_setting   = '0;
    symbol_bytes    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 14;
    receiver_idle_pct = 47;

    // radix 0 after reset: nothing comes out
    number_queue.push_back(5);
    number_queue.push_back(-5);
    settle();

    load_table(32'd10, decimal_digits);
    number_queue.push_back(0);
    number_queue.push_back(10);
    number_queue.push_back(9);
    number_queue.push_back(-1);
    number_queue.push_back(32'h7FFF_FFFF);
    number_queue.push_back(32'h8000_0000);
    number_queue.push_back(-12345);
    settle();

    // radix 2 from a word with high bits set; zero byte as a symbol
    load_table(32'hFFFF_FFE2, binary_bytes);
    number_queue.push_back(32'h8000_0000);
    number_queue.push_back(2);
    number_queue.push_back(32'h5555_5555);
    settle();

    load_table(32'd16, hex_digits);
    number_queue.push_back(16);
    number_queue.push_back(32'hDEAD_BEEF);
    number_queue.push_back(-1);
    settle();

    // unused indexes must leave the table alone
    write_register(REG_SPARE_LOW, 32'h0000_0001);
    write_register(REG_SPARE_HIGH, 32'h2B2B_2B2B);
    release_config();
    number_queue.push_back(255);
    settle();

    load_table(32'd1, decimal_digits);
    number_queue.push_back(7);
    settle();
    load_table(32'd17, decimal_digits);
    number_queue.push_back(7);
    settle();
    load_table(32'd31, hex_digits);
    number_queue.push_back(7);
    settle();
    tbl = decimal_digits;
    tbl[3:0] = 32'h3130_3130;
    load_table(32'd4, tbl);
    number_queue.push_back(7);
    settle();
    tbl[3:0] = 32'h332B_3130;
    load_table(32'd3, tbl);
    number_queue.push_back(7);
    settle();
    tbl[3:0] = 32'h332D_3130;
    load_table(32'd3, tbl);
    number_queue.push_back(7);
    settle();
    // repeat only past the radix: still a good table
    tbl[3:0] = 32'h3032_3130;
    load_table(32'd3, tbl);
    number_queue.push_back(5);
    number_queue.push_back(-9);
    settle();

    random_sent = 0;
    while (random_sent < RANDOM_NUMBERS) begin
      if (random_sent < RANDOM_NUMBERS / 3) begin
        sender_idle_pct = 14;
        receiver_idle_pct = 47;
      end else if (random_sent < 2 * RANDOM_NUMBERS / 3) begin
        sender_idle_pct = 47;
        receiver_idle_pct = 14;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      tbl = random_alphabet();
      r = $urandom_range(2, DEF_MAX_RADIX);
      case ($urandom_range(0, 9))
        0: begin
          r = $urandom_range(0, 31);
          tbl = {$urandom, $urandom, $urandom, $urandom};
        end
        1: case ($urandom_range(0, 2))
          0: tbl[$urandom_range(0, r - 1)] = SYM_PLUS;
          1: tbl[$urandom_range(0, r - 1)] = SYM_MINUS;
          default: tbl[$urandom_range(1, r - 1)] = tbl[0];
        endcase
        default: ;
      endcase
      load_table(CFG_DATA_W'(r), tbl);
      round_len = $urandom_range(5, 15);
      repeat (round_len) number_queue.push_back(random_number(r));
      random_sent += round_len;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itrd_pkg.sv
rtl/itrd_if.sv
rtl/itrd_cfg_regs.sv
rtl/itrd_sequencer.sv
rtl/itrd_datapath.sv
rtl/integer_to_radix_digits_core.sv
bench/integer_to_radix_digits_core_test.sv
